FILE: hdl/frba_pkg.sv
// ----------------------------------------------------------------------------
// frba_pkg: shared types and constants
// Field widths, codes, FSM states and inter-module structs of the frame ring
// buffer allocator.
// ----------------------------------------------------------------------------
package frba_pkg;

  localparam int ITEM_COUNT_W = 16;
  localparam int ITEM_BYTES_W = 13;
  localparam int FRAME_ID_W   = 48;
  localparam int BYTES_W      = 32;
  localparam int GRAN_W       = 17;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 32;

  // new_begin carries one bit past the 32-bit index space
  localparam int NB_W   = BYTES_W + 1;
  localparam int PROD_W = NB_W + ITEM_BYTES_W;
  // deficit plus (granularity - 1)
  localparam int REM_DVD_W = PROD_W + 1;
  localparam int REM_CNT_W = $clog2(REM_DVD_W + 1);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FRAME = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_INIT_CAP    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH_GRAN = 8'd1;

  localparam logic [BYTES_W-1:0] CAP_RESET  = 32'd65536;
  localparam logic [GRAN_W-1:0]  GRAN_RESET = 17'd65536;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AL_MUL,
    S_AL_DEC,
    S_AL_MD,
    S_AL_MN,
    S_AL_ADJ,
    S_AL_DIV,
    S_FF_RDN,
    S_FF_CMP,
    S_FF_POPRD,
    S_FF_POPCHK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [BYTES_W-1:0] offset_items;
    logic               wrapped;
    logic               chunk_grown;
    logic [BYTES_W-1:0] chunk_bytes;
    logic               error_flag;
  } res_t;

  typedef struct packed {
    logic                 start;
    logic [REM_DVD_W-1:0] dividend;
    logic [GRAN_W-1:0]    divisor;
  } rem_req_t;

  typedef struct packed {
    logic              done;
    logic [GRAN_W-1:0] rem;
  } rem_rsp_t;

endpackage

FILE: hdl/frba_in_if.sv
// ----------------------------------------------------------------------------
// frba_in_if: request channel
// Valid/ready channel carrying one allocate or frame finish request.
// ----------------------------------------------------------------------------
interface frba_in_if;
  import frba_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [ITEM_COUNT_W-1:0] item_count;
  logic [ITEM_BYTES_W-1:0] item_bytes;
  logic [FRAME_ID_W-1:0]   current_frame;
  logic [FRAME_ID_W-1:0]   completed_frame;

  modport source (
    output valid, mode, item_count, item_bytes, current_frame, completed_frame,
    input  ready
  );

  modport sink (
    input  valid, mode, item_count, item_bytes, current_frame, completed_frame,
    output ready
  );

endinterface

FILE: hdl/frba_out_if.sv
// ----------------------------------------------------------------------------
// frba_out_if: result channel
// Valid/ready channel carrying one allocation or frame finish result.
// ----------------------------------------------------------------------------
interface frba_out_if;
  import frba_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTES_W-1:0] offset_items;
  logic               wrapped;
  logic               chunk_grown;
  logic [BYTES_W-1:0] chunk_bytes;
  logic               error_flag;

  modport source (
    output valid, offset_items, wrapped, chunk_grown, chunk_bytes, error_flag,
    input  ready
  );

  modport sink (
    input  valid, offset_items, wrapped, chunk_grown, chunk_bytes, error_flag,
    output ready
  );

endinterface

FILE: hdl/frba_cfg_if.sv
// ----------------------------------------------------------------------------
// frba_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface frba_cfg_if;
  import frba_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);

endinterface

FILE: hdl/frame_ring_buffer_allocator_top.sv
// ----------------------------------------------------------------------------
// frame_ring_buffer_allocator_top: ring allocator with retired-frame fences
// Allocation state in registers, retired frames in two memories with registered reads.
// ----------------------------------------------------------------------------
// Allocate without growth: multiply (S_AL_MUL), decide (S_AL_DEC), then output (S_OUT).
// Allocate with growth: further states S_AL_MD, S_AL_MN, S_AL_ADJ and S_AL_DIV, which waits on
// the bit-serial remainder unit. Frame finish: read the newest entry, compare and push, then
// one memory read per pop until no frame can be freed or the FIFO empties.
// One request at a time; a new request is taken while a result still waits.
// Synchronous active-low reset: empty ring, capacity 65536, granularity 65536.
// ----------------------------------------------------------------------------
module frame_ring_buffer_allocator_top #(
  parameter int FRAMES_IN_FLIGHT = 8
) (
  input logic  clk,
  input logic  rst_n,
  frba_in_if.sink    in_if,
  frba_out_if.source out_if,
  frba_cfg_if.sink   cfg_if
);
  import frba_pkg::*;

  localparam int IW = $clog2(FRAMES_IN_FLIGHT);
  localparam int CW = $clog2(FRAMES_IN_FLIGHT + 1);

  state_t state_r, state_nxt;

  logic [BYTES_W-1:0] fb_r, fb_nxt;
  logic [BYTES_W-1:0] fe_r, fe_nxt;
  logic               rev_r, rev_nxt;
  logic [BYTES_W-1:0] cap_r, cap_nxt;
  logic [GRAN_W-1:0]  gran_r, gran_nxt;
  logic [IW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r, out_res_nxt;

  logic [ITEM_COUNT_W-1:0] icnt_r, icnt_nxt;
  logic [ITEM_BYTES_W-1:0] isz_r, isz_nxt;
  logic [FRAME_ID_W-1:0]   curf_r, curf_nxt;
  logic [FRAME_ID_W-1:0]   donef_r, donef_nxt;
  logic                    wrap_r, wrap_nxt;
  logic [NB_W-1:0]         nb_r, nb_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [PROD_W-1:0]       def_r, def_nxt;
  logic [REM_DVD_W-1:0]    dvd_r, dvd_nxt;
  res_t                    res_r, res_nxt;

  // retired frame memories
  logic [FRAME_ID_W-1:0] id_mem [FRAMES_IN_FLIGHT];
  logic [BYTES_W-1:0]    ue_mem [FRAMES_IN_FLIGHT];
  logic [FRAME_ID_W-1:0] id_rd_r;
  logic [BYTES_W-1:0]    ue_rd_r;
  logic                  id_we, ue_we;
  logic [IW-1:0]         wr_addr, rd_addr;
  logic [BYTES_W-1:0]    ue_wdata;

  logic [NB_W-1:0]      mul_a;
  logic [GRAN_W-1:0]    gran_eff;
  rem_req_t             rem_req;
  rem_rsp_t             rem_rsp;

  logic                 in_xfer, out_free;
  logic                 wrap_c, ovf_c, push_c, full_c, pop_c;
  logic [NB_W-1:0]      nb2_c;
  logic [IW-1:0]        slot_last, slot_next;
  logic [PROD_W-1:0]    need_m;
  logic [PROD_W-1:0]    deficit_c;
  logic [REM_DVD_W-1:0] rounded_c;
  logic [BYTES_W+15:0]  grown_c;
  logic                 sat_c;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                            input logic [CW-1:0] k);
    logic [IW:0] s;
    s = {1'b0, head} + (IW+1)'(k);
    if (s >= (IW+1)'(FRAMES_IN_FLIGHT)) s = s - (IW+1)'(FRAMES_IN_FLIGHT);
    return s[IW-1:0];
  endfunction

  frba_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_xfer      = in_if.valid && in_if.ready;
  assign out_free     = !out_valid_r || out_if.ready;

  assign gran_eff  = (gran_r == '0) ? GRAN_W'(1) : gran_r;
  assign slot_last = slot_of(head_r, cnt_r - 1'b1);
  assign slot_next = slot_of(head_r, cnt_r);

  // allocate decision, valid in S_AL_DEC
  assign wrap_c = prod_r > PROD_W'(cap_r);
  assign nb2_c  = wrap_c ? NB_W'(icnt_r) : nb_r;
  assign ovf_c  = (rev_r == wrap_c) ? (nb2_c > NB_W'(fe_r)) : wrap_c;

  // growth sizing
  assign need_m    = prod_r - PROD_W'(cap_r);
  assign deficit_c = (wrap_c && need_m > def_r) ? need_m : def_r;
  assign rounded_c = dvd_r - REM_DVD_W'(rem_rsp.rem);
  assign grown_c   = (BYTES_W+16)'(cap_r) + (BYTES_W+16)'(rounded_c);
  assign sat_c     = grown_c[BYTES_W+15:BYTES_W] != '0;

  // frame finish decisions
  assign push_c = (cnt_r == '0) || (ue_rd_r != fb_r);
  assign full_c = cnt_r >= CW'(FRAMES_IN_FLIGHT);
  assign pop_c  = id_rd_r <= donef_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = (in_if.mode == MODE_FRAME) ? S_FF_RDN : S_AL_MUL;
      end
      S_AL_MUL:    state_nxt = S_AL_DEC;
      S_AL_DEC:    state_nxt = ovf_c ? S_AL_MD : S_OUT;
      S_AL_MD:     state_nxt = S_AL_MN;
      S_AL_MN:     state_nxt = S_AL_ADJ;
      S_AL_ADJ:    state_nxt = S_AL_DIV;
      S_AL_DIV:    if (rem_rsp.done) state_nxt = S_OUT;
      S_FF_RDN:    state_nxt = S_FF_CMP;
      S_FF_CMP:    state_nxt = S_FF_POPRD;
      S_FF_POPRD:  state_nxt = (cnt_r == '0) ? S_OUT : S_FF_POPCHK;
      S_FF_POPCHK: state_nxt = pop_c ? S_FF_POPRD : S_OUT;
      S_OUT:       if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    fb_nxt        = fb_r;
    fe_nxt        = fe_r;
    rev_nxt       = rev_r;
    cap_nxt       = cap_r;
    gran_nxt      = gran_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    icnt_nxt      = icnt_r;
    isz_nxt       = isz_r;
    curf_nxt      = curf_r;
    donef_nxt     = donef_r;
    wrap_nxt      = wrap_r;
    nb_nxt        = nb_r;
    def_nxt       = def_r;
    dvd_nxt       = dvd_r;
    res_nxt       = res_r;
    id_we         = 1'b0;
    ue_we         = 1'b0;
    wr_addr       = slot_next;
    ue_wdata      = fb_r;
    rd_addr       = head_r;
    mul_a         = nb_r;
    rem_req.start    = 1'b0;
    rem_req.dividend = dvd_r;
    rem_req.divisor  = gran_eff;

    if (out_valid_r && out_if.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          icnt_nxt  = in_if.item_count;
          isz_nxt   = (in_if.item_bytes == '0) ? ITEM_BYTES_W'(1) : in_if.item_bytes;
          curf_nxt  = in_if.current_frame;
          donef_nxt = in_if.completed_frame;
          nb_nxt    = NB_W'(fb_r) + NB_W'(in_if.item_count);
        end
      end
      S_AL_MUL: mul_a = nb_r;
      S_AL_DEC: begin
        wrap_nxt             = wrap_c;
        res_nxt.offset_items = '0;
        res_nxt.wrapped      = wrap_c;
        res_nxt.chunk_grown  = 1'b0;
        res_nxt.chunk_bytes  = cap_r;
        res_nxt.error_flag   = 1'b0;
        if (ovf_c) begin
          nb_nxt = nb2_c;
        end else if (wrap_c) begin
          // the bubble at the end of the chunk goes with the newest frame
          fb_nxt  = BYTES_W'(icnt_r);
          rev_nxt = 1'b0;
          if (cnt_r != '0) begin
            ue_we    = 1'b1;
            wr_addr  = slot_last;
            ue_wdata = '0;
          end
        end else begin
          fb_nxt               = nb_r[BYTES_W-1:0];
          res_nxt.offset_items = fb_r;
        end
      end
      S_AL_MD: mul_a = (nb_r > NB_W'(fe_r)) ? (nb_r - NB_W'(fe_r)) : '0;
      S_AL_MN: begin
        def_nxt = prod_r;
        mul_a   = NB_W'(icnt_r);
      end
      S_AL_ADJ: begin
        // prod_r holds count*size here; wrap_c reads as need > capacity
        dvd_nxt          = REM_DVD_W'(deficit_c) + REM_DVD_W'(gran_eff) - 1'b1;
        rem_req.start    = 1'b1;
        rem_req.dividend = dvd_nxt;
      end
      S_AL_DIV: begin
        if (rem_rsp.done) begin
          cap_nxt              = sat_c ? '1 : grown_c[BYTES_W-1:0];
          cnt_nxt              = '0;
          head_nxt             = '0;
          fb_nxt               = BYTES_W'(icnt_r);
          fe_nxt               = '0;
          rev_nxt              = 1'b1;
          res_nxt.offset_items = '0;
          res_nxt.wrapped      = wrap_r;
          res_nxt.chunk_grown  = 1'b1;
          res_nxt.chunk_bytes  = sat_c ? '1 : grown_c[BYTES_W-1:0];
          res_nxt.error_flag   = sat_c;
        end
      end
      S_FF_RDN: rd_addr = slot_last;
      S_FF_CMP: begin
        res_nxt.offset_items = '0;
        res_nxt.wrapped      = 1'b0;
        res_nxt.chunk_grown  = 1'b0;
        res_nxt.chunk_bytes  = cap_r;
        res_nxt.error_flag   = push_c && full_c;
        if (push_c && !full_c) begin
          id_we   = 1'b1;
          ue_we   = 1'b1;
          wr_addr = slot_next;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FF_POPRD: begin
        rd_addr = head_r;
        if (cnt_r == '0) begin
          head_nxt = '0;
          fb_nxt   = '0;
          fe_nxt   = '0;
          rev_nxt  = 1'b1;
        end
      end
      S_FF_POPCHK: begin
        if (pop_c) begin
          if (ue_rd_r < fe_r) rev_nxt = 1'b1;
          fe_nxt   = ue_rd_r;
          head_nxt = (head_r == IW'(FRAMES_IN_FLIGHT - 1)) ? '0 : head_r + 1'b1;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
        end
      end
      default: ;
    endcase

    // written only while idle by the user; the block itself does not enforce it
    if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        REG_INIT_CAP:    cap_nxt = (cfg_if.data == '0) ? BYTES_W'(1) : cfg_if.data;
        REG_GROWTH_GRAN: gran_nxt = cfg_if.data[GRAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(isz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fb_r        <= '0;
      fe_r        <= '0;
      rev_r       <= 1'b1;
      cap_r       <= CAP_RESET;
      gran_r      <= GRAN_RESET;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fb_r        <= fb_nxt;
      fe_r        <= fe_nxt;
      rev_r       <= rev_nxt;
      cap_r       <= cap_nxt;
      gran_r      <= gran_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    icnt_r    <= icnt_nxt;
    isz_r     <= isz_nxt;
    curf_r    <= curf_nxt;
    donef_r   <= donef_nxt;
    wrap_r    <= wrap_nxt;
    nb_r      <= nb_nxt;
    prod_r    <= prod_nxt;
    def_r     <= def_nxt;
    dvd_r     <= dvd_nxt;
    res_r     <= res_nxt;
  end

  // accesses are sequenced by the FSM; a read that meets a write to the same
  // entry in one cycle is never used
  always_ff @(posedge clk) begin
    if (id_we) id_mem[wr_addr] <= curf_r;
    if (ue_we) ue_mem[wr_addr] <= ue_wdata;
    id_rd_r <= id_mem[rd_addr];
    ue_rd_r <= ue_mem[rd_addr];
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.offset_items = out_res_r.offset_items;
  assign out_if.wrapped      = out_res_r.wrapped;
  assign out_if.chunk_grown  = out_res_r.chunk_grown;
  assign out_if.chunk_bytes  = out_res_r.chunk_bytes;
  assign out_if.error_flag   = out_res_r.error_flag;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(FRAMES_IN_FLIGHT))
    else $error("retired frame count past capacity");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    id_we |-> (cnt_r < CW'(FRAMES_IN_FLIGHT) && state_r == S_FF_CMP))
    else $error("frame recorded into a full FIFO");

  a_rem_done: assert property (@(posedge clk) disable iff (!rst_n)
    rem_rsp.done |-> state_r == S_AL_DIV)
    else $error("remainder result outside growth sizing");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded on leaving output state");

  a_cap_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> cap_r != '0)
    else $error("zero chunk capacity");

endmodule

FILE: hdl/frba_rem_unit.sv
// ----------------------------------------------------------------------------
// frba_rem_unit: iterative remainder unit
// Restoring division, one dividend bit per cycle; returns the remainder only.
// ----------------------------------------------------------------------------
module frba_rem_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  frba_pkg::rem_req_t req,
  output frba_pkg::rem_rsp_t rsp
);
  import frba_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [REM_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_DVD_W-1:0] dvd_r, dvd_nxt;
  logic [GRAN_W-1:0]    dvs_r, dvs_nxt;
  logic [GRAN_W-1:0]    rem_r, rem_nxt;
  logic [GRAN_W:0]      trial;
  logic [GRAN_W:0]      trial_sub;
  logic                 trial_ge;

  assign trial     = {rem_r, dvd_r[REM_DVD_W-1]};
  assign trial_ge  = trial >= {1'b0, dvs_r};
  assign trial_sub = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = REM_CNT_W'(REM_DVD_W);
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the top trial bit drops out
      rem_nxt = trial_ge ? trial_sub[GRAN_W-1:0] : trial[GRAN_W-1:0];
      dvd_nxt = {dvd_r[REM_DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == REM_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
